// File: design/priority_aging_scheduler_assert.svh
// Assertion macros for the priority aging scheduler.
// Used by the top level; no other dependencies.
`ifndef PRIORITY_AGING_SCHEDULER_ASSERT_SVH
`define PRIORITY_AGING_SCHEDULER_ASSERT_SVH
`ifndef ASSERT_OFF
`define PAS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("assertion failed: same-cycle implication");
`define PAS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("assertion failed: next-cycle implication");
`else
`define PAS_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define PAS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: design/pas_pkg.sv
// Shared types and constants for the priority aging scheduler.
// No dependencies.
package pas_pkg;

	localparam int CAPACITY_DEF = 8;
	localparam int DATA_W       = 8;
	localparam int QCOUNT_W     = 4;
	localparam logic [DATA_W-1:0] AGING_RESET = 8'd3;

	localparam logic CMD_ADD = 1'b0;
	localparam logic CMD_RUN = 1'b1;

	localparam logic REG_AGING_STEP = 1'b0;

	typedef struct packed {
		logic              command;
		logic [DATA_W-1:0] proc_id;
		logic [DATA_W-1:0] priority_req;
		logic [DATA_W-1:0] run_time;
	} in_beat_t;

	typedef struct packed {
		logic [DATA_W-1:0]   ran_id;
		logic [DATA_W-1:0]   ran_priority;
		logic [DATA_W-1:0]   ran_remaining;
		logic                finished;
		logic                idle;
		logic                add_dropped;
		logic [QCOUNT_W-1:0] queue_count;
	} out_beat_t;

	typedef struct packed {
		logic [DATA_W-1:0] id;
		logic [DATA_W-1:0] prio;
		logic [DATA_W-1:0] rem;
	} entry_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD_HEAD,
		ST_HEAD,
		ST_WALK_RD,
		ST_WALK,
		ST_PUT,
		ST_DONE
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic accept;
		logic set_drop;
		logic set_idle;
		logic rd_head;
		logic take_head;
		logic rd_walk;
		logic shift;
		logic put;
		logic load_out;
	} ctrl_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic count_zero;
		logic count_full;
		logic head_fin;
		logic hole_zero;
		logic walk_ge;
		logic out_free;
	} dp_status_t;

endpackage

// File: design/priority_aging_scheduler.sv
// Each beat runs to completion before the next: an add walks from the tail and inserts;
// a run reads and ages the head, then reinserts it unless its slice finishes; a dropped
// add or idle run goes straight to the result load. One item at a time, the next beat
// accepted the cycle after the result load; the result load waits while the output stalls.
// Reset empties the queue, drops any pending beat and sets aging_step to 3; memory not reset.
// Depends on pas_pkg, pas_ctrl, pas_dp and priority_aging_scheduler_assert.svh.
`include "priority_aging_scheduler_assert.svh"
module priority_aging_scheduler #(
	parameter int CAPACITY = pas_pkg::CAPACITY_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	// item input
	input  logic               in_valid,
	output logic               in_stall,
	input  pas_pkg::in_beat_t  in_data,
	// result output
	output logic               out_valid,
	input  logic               out_stall,
	output pas_pkg::out_beat_t out_data,
	// register port
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [1:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);
	import pas_pkg::*;

	ctrl_cmd_t         cmd;
	dp_status_t        status;
	logic [DATA_W-1:0] aging_step_q;
	logic              reg_sel;

	// Only one register, aging_step: writes with paddr[1] low reach it, and every read returns it.
	assign reg_sel = (paddr[1] == REG_AGING_STEP);
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			aging_step_q <= AGING_RESET;
		end else if (psel && penable && pwrite && reg_sel) begin
			aging_step_q <= pwdata[DATA_W-1:0];
		end
	end

	assign prdata = {{(32 - DATA_W - 1){1'b0}}, paddr[0] & 1'b0, aging_step_q};

	// Controller: accepts one beat in idle, then steps the datapath through
	// the head read, the insertion walk from the tail and the result load.
	pas_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_cmd   (in_data.command),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	// Datapath: circular queue in memory, one read and one write per cycle.
	pas_dp #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_data    (in_data),
		.aging_step (aging_step_q),
		.cmd        (cmd),
		.status     (status),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_data   (out_data)
	);

	// An accepted beat always takes the controller out of idle in the next cycle.
	`PAS_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && !in_stall, in_stall)
	// Never insert into a full queue.
	`PAS_ASSERT_IMPL(a_put_not_full, clk, arst_n, cmd.put, !status.count_full)
	// Result only loaded when the output register is free.
	`PAS_ASSERT_IMPL(a_load_free, clk, arst_n, cmd.load_out, status.out_free)
	// Head is only popped from a non-empty queue.
	`PAS_ASSERT_IMPL(a_pop_nonempty, clk, arst_n, cmd.take_head, !status.count_zero)

endmodule

// File: design/pas_ctrl.sv
// Sequencing state machine of the priority aging scheduler.
// Depends on pas_pkg.
module pas_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_cmd,
	output logic                in_stall,
	input  pas_pkg::dp_status_t status,
	output pas_pkg::ctrl_cmd_t  cmd
);
	import pas_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_stall = (state_q != ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					if (in_cmd == CMD_ADD) begin
						if (status.count_full) begin
							cmd.set_drop = 1'b1;
							state_d      = ST_DONE;
						end else begin
							state_d = ST_WALK_RD;
						end
					end else begin
						if (status.count_zero) begin
							cmd.set_idle = 1'b1;
							state_d      = ST_DONE;
						end else begin
							state_d = ST_RD_HEAD;
						end
					end
				end
			end
			ST_RD_HEAD: begin
				cmd.rd_head = 1'b1;
				state_d     = ST_HEAD;
			end
			ST_HEAD: begin
				cmd.take_head = 1'b1;
				state_d       = status.head_fin ? ST_DONE : ST_WALK_RD;
			end
			ST_WALK_RD: begin
				if (status.hole_zero) begin
					state_d = ST_PUT;
				end else begin
					cmd.rd_walk = 1'b1;
					state_d     = ST_WALK;
				end
			end
			ST_WALK: begin
				if (status.walk_ge) begin
					state_d = ST_PUT;
				end else begin
					cmd.shift = 1'b1;
					state_d   = ST_WALK_RD;
				end
			end
			ST_PUT: begin
				cmd.put = 1'b1;
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (status.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// File: design/pas_dp.sv
// Datapath: circular queue memory, insertion walk, aging and result registers.
// Depends on pas_pkg.
module pas_dp #(
	parameter int CAPACITY = pas_pkg::CAPACITY_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  pas_pkg::in_beat_t                  in_data,
	input  logic [pas_pkg::DATA_W-1:0]         aging_step,
	input  pas_pkg::ctrl_cmd_t                 cmd,
	output pas_pkg::dp_status_t                status,
	output logic                               out_valid,
	input  logic                               out_stall,
	output pas_pkg::out_beat_t                 out_data
);
	import pas_pkg::*;

	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int SUM_W = CNT_W + 1;
	localparam logic [SUM_W-1:0] CAP_S   = SUM_W'(CAPACITY);
	localparam logic [IDX_W-1:0] LAST_IX = IDX_W'(CAPACITY - 1);

	entry_t mem [CAPACITY];

	logic [IDX_W-1:0] head_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] hole_q;
	entry_t           ent_q;
	entry_t           rd_q;
	out_beat_t        res_q;
	out_beat_t        out_q;
	logic             out_valid_q;

	logic [CNT_W-1:0] hole_m1;
	logic [SUM_W-1:0] sum_rd, sum_wr;
	logic [IDX_W-1:0] rd_addr, wr_addr;
	logic             wr_en;
	entry_t           wr_data;
	logic [DATA_W-1:0] rem_dec, prio_aged;
	logic             fin;

	assign hole_m1 = hole_q - CNT_W'(1);

	// logical position -> physical slot, wrapping once at CAPACITY
	always_comb begin
		sum_rd = SUM_W'(head_q) + SUM_W'(cmd.rd_head ? CNT_W'(0) : hole_m1);
		sum_wr = SUM_W'(head_q) + SUM_W'(hole_q);
		if (sum_rd >= CAP_S) sum_rd = sum_rd - CAP_S;
		if (sum_wr >= CAP_S) sum_wr = sum_wr - CAP_S;
		rd_addr = sum_rd[IDX_W-1:0];
		wr_addr = sum_wr[IDX_W-1:0];
	end

	assign wr_en   = cmd.shift | cmd.put;
	assign wr_data = cmd.shift ? rd_q : ent_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (cmd.rd_head | cmd.rd_walk) begin
			rd_q <= mem[rd_addr];
		end
	end

	// head slice: saturating decrement, aging saturates at zero
	assign rem_dec   = (rd_q.rem != '0) ? rd_q.rem - DATA_W'(1) : '0;
	assign fin       = (rem_dec == '0);
	assign prio_aged = (rd_q.prio >= aging_step) ? rd_q.prio - aging_step : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
		end else begin
			if (cmd.take_head) begin
				head_q  <= (head_q == LAST_IX) ? '0 : head_q + IDX_W'(1);
				count_q <= count_q - CNT_W'(1);
			end else if (cmd.put) begin
				count_q <= count_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			ent_q  <= '{id: in_data.proc_id, prio: in_data.priority_req,
				rem: in_data.run_time};
			hole_q <= count_q;
			res_q  <= '{ran_id: '0, ran_priority: '0, ran_remaining: '0, finished: 1'b0,
				idle: cmd.set_idle, add_dropped: cmd.set_drop, queue_count: '0};
		end else if (cmd.take_head) begin
			ent_q  <= '{id: rd_q.id, prio: prio_aged, rem: rem_dec};
			hole_q <= count_q - CNT_W'(1);
			res_q.ran_id        <= rd_q.id;
			res_q.ran_priority  <= fin ? rd_q.prio : prio_aged;
			res_q.ran_remaining <= rem_dec;
			res_q.finished      <= fin;
		end else if (cmd.shift) begin
			hole_q <= hole_m1;
		end
	end

	// output register, freed as soon as the downstream takes the beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_q <= '{ran_id: res_q.ran_id, ran_priority: res_q.ran_priority,
				ran_remaining: res_q.ran_remaining, finished: res_q.finished,
				idle: res_q.idle, add_dropped: res_q.add_dropped,
				queue_count: QCOUNT_W'(count_q)};
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign status.count_zero = (count_q == '0);
	assign status.count_full = (count_q >= CNT_W'(CAPACITY));
	assign status.head_fin   = fin;
	assign status.hole_zero  = (hole_q == '0);
	assign status.walk_ge    = (rd_q.prio >= ent_q.prio);
	assign status.out_free   = !out_valid_q || !out_stall;

endmodule
